[rtl/core/lpmr_pkg.sv]
// ----------------------------------------------------------------------------
// lpmr_pkg
// Types and codes shared by the length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

    typedef enum logic [1:0] {
        OP_START_WRITE = 2'd0,
        OP_WRITE_BYTE  = 2'd1,
        OP_START_READ  = 2'd2,
        OP_READ_BYTE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_TOOLONG = 3'd3,
        ST_SEQ     = 3'd4
    } status_t;

    localparam int LEN_W  = 12;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int LANES  = WORD_W / BYTE_W;

    typedef struct packed {
        op_t                operation;
        logic [LEN_W-1:0]   message_length;
        logic [LEN_W-1:0]   max_length;
        logic [BYTE_W-1:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   length_out;
        logic [BYTE_W-1:0]  byte_out;
        logic               last;
    } out_item_t;

endpackage

[rtl/core/lpmr_store.sv]
// ----------------------------------------------------------------------------
// lpmr_store
// Word store of the message ring: one read port with registered data and one
// write port with a write enable per byte lane.
// ----------------------------------------------------------------------------
module lpmr_store
    import lpmr_pkg::*;
#(
    parameter int WORDS = 1024
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [$clog2(WORDS)-1:0]   rd_addr,
    output logic [WORD_W-1:0]          rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(WORDS)-1:0]   wr_addr,
    input  logic [LANES-1:0]           wr_lanes,
    input  logic [WORD_W-1:0]          wr_data
);

    logic [WORD_W-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            if (wr_en && wr_lanes[i]) begin
                mem[wr_addr][i*BYTE_W +: BYTE_W] <= wr_data[i*BYTE_W +: BYTE_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/length_prefixed_message_ring.sv]
// ----------------------------------------------------------------------------
// length_prefixed_message_ring
// Circular byte store of variable-length messages, each a word-aligned length
// header followed by its payload, moved one byte per item.
// ----------------------------------------------------------------------------
// Usage: the s_ channel takes one operation per item (start write, write a
// payload byte, start read, read a payload byte); every item gives exactly one
// result item on the m_ channel with a status, the message length, a payload
// byte and a last flag.
// Timing: the store word is registered as the item is accepted; the item is
// processed in the following cycle, which writes its result to the output
// register. The item is held while the store read completes and the
// read-modify-write of the counters takes place; the next item is accepted
// only after that, so no forwarding is needed.
// Reset: aresetn clears all counters and the open flags, giving an empty ring.
// The store itself is not cleared; only published headers and bytes are read.
// Stall: the output register holds a result until m_ready; a new item is
// accepted in the same cycle that a waiting result is taken, not before.
// Counters are published only when a whole message has been moved.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring
    import lpmr_pkg::*;
#(
    parameter int STORE_WORDS = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam int CW = $clog2(STORE_WORDS * 8);
    localparam int NW = (CW + 1 > LEN_W + 1) ? CW + 1 : LEN_W + 1;
    localparam logic [CW:0] RING_C = (CW+1)'(STORE_WORDS * 4);
    localparam logic [CW:0] SPAN_C = (CW+1)'(STORE_WORDS * 8);

    function automatic logic [CW-1:0] span_wrap(input logic [CW:0] c);
        logic [CW:0] t;
        t = (c >= SPAN_C) ? c - SPAN_C : c;
        return t[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] align_up(input logic [CW-1:0] c);
        logic [CW:0] t;
        t = ({1'b0, c} + (CW+1)'(3)) & ~(CW+1)'(3);
        return span_wrap(t);
    endfunction

    function automatic logic [AW-1:0] word_of(input logic [CW-1:0] c);
        logic [CW-1:0] p;
        p = ({1'b0, c} >= RING_C) ? c - RING_C[CW-1:0] : c;
        return p[AW+1:2];
    endfunction

    // Counters and cursors
    logic [CW-1:0]    read_count_reg, read_count_next;
    logic [CW-1:0]    write_count_reg, write_count_next;
    logic [CW-1:0]    write_cursor_reg, write_cursor_next;
    logic [CW-1:0]    read_cursor_reg, read_cursor_next;
    logic [LEN_W-1:0] write_left_reg, write_left_next;
    logic [LEN_W-1:0] read_left_reg, read_left_next;
    logic             write_open_reg, write_open_next;
    logic             read_open_reg, read_open_next;

    logic             busy_reg, busy_next;
    in_item_t         item_reg;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    // Store ports
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [LANES-1:0]   wr_lanes;
    logic [WORD_W-1:0]  wr_data;

    logic               accept;
    logic [CW-1:0]      wr_at;
    logic [CW-1:0]      rd_at;
    logic [CW:0]        used;
    logic [NW-1:0]      room;
    logic [NW-1:0]      need;
    logic [CW-1:0]      wr_at_end;
    logic [CW-1:0]      rd_at_end;
    logic [CW-1:0]      wr_cur_inc;
    logic [CW-1:0]      rd_cur_inc;
    logic [LEN_W-1:0]   write_left_dec;
    logic [LEN_W-1:0]   read_left_dec;

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign wr_at = align_up(write_count_reg);
    assign rd_at = align_up(read_count_reg);

    // Bytes held from the reader's position up to the new header position.
    assign used = (wr_at >= read_count_reg)
                ? {1'b0, wr_at} - {1'b0, read_count_reg}
                : {1'b0, wr_at} + SPAN_C - {1'b0, read_count_reg};
    assign room = (used >= RING_C) ? '0 : NW'(RING_C - used);
    assign need = NW'(item_reg.message_length) + NW'(4);

    assign wr_at_end      = span_wrap({1'b0, wr_at} + (CW+1)'(4));
    assign rd_at_end      = span_wrap({1'b0, rd_at} + (CW+1)'(4));
    assign wr_cur_inc     = span_wrap({1'b0, write_cursor_reg} + (CW+1)'(1));
    assign rd_cur_inc     = span_wrap({1'b0, read_cursor_reg} + (CW+1)'(1));
    assign write_left_dec = write_left_reg - LEN_W'(1);
    assign read_left_dec  = read_left_reg - LEN_W'(1);

    // The store is read as the item is accepted; the word is ready next cycle.
    assign rd_en   = accept;
    assign rd_addr = (s_item.operation == OP_START_READ) ? word_of(rd_at)
                                                         : word_of(read_cursor_reg);

    lpmr_store #(
        .WORDS (STORE_WORDS)
    ) u_store (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_lanes (wr_lanes),
        .wr_data  (wr_data)
    );

    always_comb begin
        read_count_next   = read_count_reg;
        write_count_next  = write_count_reg;
        write_cursor_next = write_cursor_reg;
        read_cursor_next  = read_cursor_reg;
        write_left_next   = write_left_reg;
        read_left_next    = read_left_reg;
        write_open_next   = write_open_reg;
        read_open_next    = read_open_reg;
        busy_next         = busy_reg;
        m_valid_next      = m_valid_reg;
        m_item_next       = m_item_reg;
        wr_en             = 1'b0;
        wr_addr           = word_of(wr_at);
        wr_lanes          = '0;
        wr_data           = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            busy_next = 1'b1;
        end

        if (busy_reg) begin
            busy_next              = 1'b0;
            m_valid_next           = 1'b1;
            m_item_next.status     = ST_OK;
            m_item_next.length_out = '0;
            m_item_next.byte_out   = '0;
            m_item_next.last       = 1'b0;

            case (item_reg.operation)
                OP_START_WRITE: begin
                    // A restart drops the open message; nothing of it was published.
                    write_open_next = 1'b0;
                    if (need > room) begin
                        m_item_next.status = ST_NOSPACE;
                    end else begin
                        wr_en             = 1'b1;
                        wr_addr           = word_of(wr_at);
                        wr_lanes          = '1;
                        wr_data           = WORD_W'(item_reg.message_length);
                        write_cursor_next = wr_at_end;
                        write_left_next   = item_reg.message_length;
                        if (item_reg.message_length == '0) begin
                            write_count_next = wr_at_end;
                            m_item_next.last = 1'b1;
                        end else begin
                            write_open_next = 1'b1;
                        end
                    end
                end
                OP_WRITE_BYTE: begin
                    if (!write_open_reg) begin
                        m_item_next.status = ST_SEQ;
                    end else begin
                        wr_en             = 1'b1;
                        wr_addr           = word_of(write_cursor_reg);
                        wr_lanes          = LANES'(1) << write_cursor_reg[1:0];
                        wr_data           = {LANES{item_reg.data_byte}};
                        write_cursor_next = wr_cur_inc;
                        write_left_next   = write_left_dec;
                        if (write_left_dec == '0) begin
                            write_count_next = wr_cur_inc;
                            write_open_next  = 1'b0;
                            m_item_next.last = 1'b1;
                        end
                    end
                end
                OP_START_READ: begin
                    read_open_next = 1'b0;
                    if (read_count_reg == write_count_reg) begin
                        m_item_next.status = ST_EMPTY;
                    end else begin
                        m_item_next.length_out = rd_data[LEN_W-1:0];
                        if (rd_data > WORD_W'(item_reg.max_length)) begin
                            m_item_next.status = ST_TOOLONG;
                        end else begin
                            read_cursor_next = rd_at_end;
                            read_left_next   = rd_data[LEN_W-1:0];
                            if (rd_data[LEN_W-1:0] == '0) begin
                                read_count_next  = rd_at_end;
                                m_item_next.last = 1'b1;
                            end else begin
                                read_open_next = 1'b1;
                            end
                        end
                    end
                end
                OP_READ_BYTE: begin
                    if (!read_open_reg) begin
                        m_item_next.status = ST_SEQ;
                    end else begin
                        m_item_next.byte_out =
                            rd_data[read_cursor_reg[1:0]*BYTE_W +: BYTE_W];
                        read_cursor_next = rd_cur_inc;
                        read_left_next   = read_left_dec;
                        if (read_left_dec == '0) begin
                            read_count_next  = rd_cur_inc;
                            read_open_next   = 1'b0;
                            m_item_next.last = 1'b1;
                        end
                    end
                end
                default: begin
                    m_item_next.status = ST_SEQ;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_count_reg   <= '0;
            write_count_reg  <= '0;
            write_cursor_reg <= '0;
            read_cursor_reg  <= '0;
            write_left_reg   <= '0;
            read_left_reg    <= '0;
            write_open_reg   <= 1'b0;
            read_open_reg    <= 1'b0;
            busy_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            read_count_reg   <= read_count_next;
            write_count_reg  <= write_count_next;
            write_cursor_reg <= write_cursor_next;
            read_cursor_reg  <= read_cursor_next;
            write_left_reg   <= write_left_next;
            read_left_reg    <= read_left_next;
            write_open_reg   <= write_open_next;
            read_open_reg    <= read_open_next;
            busy_reg         <= busy_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
        m_item_reg <= m_item_next;
    end

    // Published fill level, for checking only.
    logic [CW:0] pub_used;
    assign pub_used = (write_count_reg >= read_count_reg)
                    ? {1'b0, write_count_reg} - {1'b0, read_count_reg}
                    : {1'b0, write_count_reg} + SPAN_C - {1'b0, read_count_reg};

    // While an item is being processed the output register must be free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !m_valid_reg)
        else $error("result register occupied while an item is in process");

    // An accepted item is processed in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && !s_ready)
        else $error("accepted item not held for processing");

    // An open message always has bytes left to move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!write_open_reg || write_left_reg != '0) &&
        (!read_open_reg || read_left_reg != '0))
        else $error("open message with no bytes left");

    // The published messages never hold more than the whole store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pub_used <= RING_C)
        else $error("published fill level exceeds the store size");

endmodule

[tb/length_prefixed_message_ring_tb.sv]
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_tb
// Self-checking bench for the length-prefixed message ring. A short scripted
// sequence covers the field extremes, the error codes and restarts. It is
// followed by random message traffic that writes, reads, abandons and restarts
// messages. Every result item is checked against a cycle-free model of the
// ring held in the bench, or, where a scripted row gives a reply, against it.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_tb;
    import lpmr_pkg::*;

    localparam int RING_WORDS   = 1024;
    localparam int RING_BYTES   = RING_WORDS * LANES;
    // The counters run modulo twice the store size. With a power-of-two store
    // that is plain wrap-around arithmetic at this width.
    localparam int CNT_W        = $clog2(2 * RING_BYTES);
    localparam int IDX_W        = $clog2(RING_WORDS);
    localparam int LEN_MAX      = (1 << LEN_W) - 1;
    localparam int RANDOM_ITEMS = 875;
    localparam int TAIL_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t reply;
    } script_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Bench copy of the ring.
    logic [WORD_W-1:0] ring_words [RING_WORDS];
    logic [CNT_W-1:0]  rd_count = '0;
    logic [CNT_W-1:0]  wr_count = '0;
    logic [CNT_W-1:0]  rd_cur   = '0;
    logic [CNT_W-1:0]  wr_cur   = '0;
    logic [LEN_W-1:0]  rd_left  = '0;
    logic [LEN_W-1:0]  wr_left  = '0;
    bit                rd_open  = 1'b0;
    bit                wr_open  = 1'b0;

    out_item_t   ring_replies [$];
    script_row_t script [$];
    out_item_t   want;
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    bit          quiet       = 1'b0;
    bit          filling     = 1'b1;

    length_prefixed_message_ring #(
        .STORE_WORDS (RING_WORDS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] align_word(logic [CNT_W-1:0] c);
        return (c + CNT_W'(3)) & ~CNT_W'(3);
    endfunction

    // Bytes a start write may claim for header plus payload.
    function automatic int free_bytes();
        logic [CNT_W-1:0] used;
        used = align_word(wr_count) - rd_count;
        return (used >= RING_BYTES) ? 0 : RING_BYTES - int'(used);
    endfunction

    function automatic out_item_t ring_reply_of(in_item_t it);
        out_item_t        r;
        logic [CNT_W-1:0] at;
        logic [WORD_W-1:0] hdr;
        r = '0;
        r.status = ST_OK;
        case (it.operation)
            OP_START_WRITE: begin
                at = align_word(wr_count);
                wr_open = 1'b0;
                if (int'(it.message_length) + LANES > free_bytes()) begin
                    r.status = ST_NOSPACE;
                end else begin
                    ring_words[at[IDX_W+1:2]] = WORD_W'(it.message_length);
                    wr_cur  = at + CNT_W'(LANES);
                    wr_left = it.message_length;
                    if (it.message_length == 0) begin
                        wr_count = wr_cur;
                        r.last = 1'b1;
                    end else begin
                        wr_open = 1'b1;
                    end
                end
            end
            OP_WRITE_BYTE: begin
                if (!wr_open) begin
                    r.status = ST_SEQ;
                end else begin
                    ring_words[wr_cur[IDX_W+1:2]][wr_cur[1:0]*BYTE_W +: BYTE_W] = it.data_byte;
                    wr_cur  = wr_cur + 1'b1;
                    wr_left = wr_left - 1'b1;
                    if (wr_left == 0) begin
                        wr_count = wr_cur;
                        wr_open  = 1'b0;
                        r.last   = 1'b1;
                    end
                end
            end
            OP_START_READ: begin
                rd_open = 1'b0;
                if (rd_count == wr_count) begin
                    r.status = ST_EMPTY;
                end else begin
                    at  = align_word(rd_count);
                    hdr = ring_words[at[IDX_W+1:2]];
                    r.length_out = hdr[LEN_W-1:0];
                    if (hdr > it.max_length) begin
                        r.status = ST_TOOLONG;
                    end else begin
                        rd_cur  = at + CNT_W'(LANES);
                        rd_left = hdr[LEN_W-1:0];
                        if (rd_left == 0) begin
                            rd_count = rd_cur;
                            r.last = 1'b1;
                        end else begin
                            rd_open = 1'b1;
                        end
                    end
                end
            end
            OP_READ_BYTE: begin
                if (!rd_open) begin
                    r.status = ST_SEQ;
                end else begin
                    r.byte_out = ring_words[rd_cur[IDX_W+1:2]][rd_cur[1:0]*BYTE_W +: BYTE_W];
                    rd_cur  = rd_cur + 1'b1;
                    rd_left = rd_left - 1'b1;
                    if (rd_left == 0) begin
                        rd_count = rd_cur;
                        rd_open  = 1'b0;
                        r.last   = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic in_item_t pack_item(op_t op, int mlen, int maxl, int data);
        in_item_t it;
        it.operation      = op;
        it.message_length = LEN_W'(mlen);
        it.max_length     = LEN_W'(maxl);
        it.data_byte      = BYTE_W'(data);
        return it;
    endfunction

    function automatic out_item_t pack_reply(status_t st, int len, int data, bit last);
        out_item_t r;
        r.status     = st;
        r.length_out = LEN_W'(len);
        r.byte_out   = BYTE_W'(data);
        r.last       = last;
        return r;
    endfunction

    // Fields that the operation ignores still carry random values.
    function automatic in_item_t rand_item(op_t op);
        return pack_item(op, $urandom_range(0, LEN_MAX), $urandom_range(0, LEN_MAX),
                         $urandom_range(0, 255));
    endfunction

    // Mostly short messages so the counters travel far; a few long ones.
    function automatic int pick_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 80) return $urandom_range(1, 8);
        if (p < 96) return $urandom_range(9, 40);
        return $urandom_range(41, 255);
    endfunction

    task automatic push_item(in_item_t it, bit typed, out_item_t given);
        out_item_t r;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        r = ring_reply_of(it);
        ring_replies.push_back(typed ? given : r);
        items_sent++;
    endtask

    // One message written or read, sometimes cut short, or a single stray item.
    task automatic random_episode();
        int               pick;
        int               len;
        int               n;
        int               hlen;
        logic [CNT_W-1:0] at;
        in_item_t         it;
        pick = $urandom_range(0, 99);
        if (filling ? pick < 70 : pick < 15) begin
            len = pick_length();
            // Near the top, aim at filling the store exactly.
            if (free_bytes() < 80 && $urandom_range(0, 1) == 1)
                len = (free_bytes() >= LANES) ? free_bytes() - LANES : 0;
            it = rand_item(OP_START_WRITE);
            it.message_length = LEN_W'(len);
            push_item(it, 1'b0, '0);
            n = wr_open ? int'(wr_left) : 0;
            if (n > 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
            repeat (n) push_item(rand_item(OP_WRITE_BYTE), 1'b0, '0);
        end else if (pick < 85) begin
            it = rand_item(OP_START_READ);
            if (rd_count != wr_count) begin
                at   = align_word(rd_count);
                hlen = int'(ring_words[at[IDX_W+1:2]]);
                case ($urandom_range(0, 9))
                    0, 1: begin
                        it.max_length = LEN_W'(hlen > 0 ? $urandom_range(0, hlen - 1) : 0);
                    end
                    2, 3: it.max_length = LEN_W'(hlen);
                    4: it.max_length = LEN_W'(LEN_MAX);
                    default: it.max_length = LEN_W'($urandom_range(hlen, LEN_MAX));
                endcase
            end
            push_item(it, 1'b0, '0);
            n = rd_open ? int'(rd_left) : 0;
            if (n > 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
            repeat (n) push_item(rand_item(OP_READ_BYTE), 1'b0, '0);
        end else begin
            push_item(rand_item(op_t'($urandom_range(0, 3))), 1'b0, '0);
        end
        if (filling && free_bytes() < 8)
            filling = 1'b0;
        else if (!filling && rd_count == wr_count)
            filling = 1'b1;
    endtask

    initial begin : ready_gen
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (ring_replies.size() == 0) begin
                $error("result item with nothing pending: status %0d", m_item.status);
                mismatches++;
            end else begin
                want = ring_replies.pop_front();
                if (m_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_item.status);
                    mismatches++;
                end
                if (m_item.length_out !== want.length_out) begin
                    $error("length_out: expected %0d, got %0d", want.length_out,
                           m_item.length_out);
                    mismatches++;
                end
                if (m_item.byte_out !== want.byte_out) begin
                    $error("byte_out: expected 0x%02h, got 0x%02h", want.byte_out,
                           m_item.byte_out);
                    mismatches++;
                end
                if (m_item.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_item.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int mark;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        foreach (ring_words[i]) ring_words[i] = '0;

        // Empty ring and stray bytes.
        script.push_back('{pack_item(OP_START_READ, 0, LEN_MAX, 0), 1'b1,
                           pack_reply(ST_EMPTY, 0, 0, 1'b0)});
        script.push_back('{pack_item(OP_READ_BYTE, 0, 0, 0), 1'b1,
                           pack_reply(ST_SEQ, 0, 0, 1'b0)});
        script.push_back('{pack_item(OP_WRITE_BYTE, LEN_MAX, LEN_MAX, 8'hFF), 1'b1,
                           pack_reply(ST_SEQ, 0, 0, 1'b0)});
        // Lengths that can never fit, then a zero-length message.
        script.push_back('{pack_item(OP_START_WRITE, LEN_MAX, 0, 0), 1'b1,
                           pack_reply(ST_NOSPACE, 0, 0, 1'b0)});
        script.push_back('{pack_item(OP_START_WRITE, 4093, 0, 0), 1'b1,
                           pack_reply(ST_NOSPACE, 0, 0, 1'b0)});
        script.push_back('{pack_item(OP_START_WRITE, 0, 0, 0), 1'b1,
                           pack_reply(ST_OK, 0, 0, 1'b1)});
        // The largest payload no longer fits once one header is stored.
        script.push_back('{pack_item(OP_START_WRITE, 4092, 0, 0), 1'b1,
                           pack_reply(ST_NOSPACE, 0, 0, 1'b0)});
        // A write abandoned part way and restarted with a new length.
        script.push_back('{pack_item(OP_START_WRITE, 3, 0, 0), 1'b0, '0});
        script.push_back('{pack_item(OP_WRITE_BYTE, 0, 0, 8'h00), 1'b0, '0});
        script.push_back('{pack_item(OP_WRITE_BYTE, 0, 0, 8'hFF), 1'b0, '0});
        script.push_back('{pack_item(OP_START_WRITE, 2, 0, 0), 1'b0, '0});
        script.push_back('{pack_item(OP_WRITE_BYTE, 0, 0, 8'hA5), 1'b0, '0});
        script.push_back('{pack_item(OP_WRITE_BYTE, 0, 0, 8'h5A), 1'b0, '0});
        script.push_back('{pack_item(OP_START_READ, 0, 0, 0), 1'b1,
                           pack_reply(ST_OK, 0, 0, 1'b1)});
        script.push_back('{pack_item(OP_START_READ, 0, 1, 0), 1'b1,
                           pack_reply(ST_TOOLONG, 2, 0, 1'b0)});
        script.push_back('{pack_item(OP_START_READ, 0, 2, 0), 1'b0, '0});
        script.push_back('{pack_item(OP_READ_BYTE, 0, 0, 0), 1'b0, '0});
        script.push_back('{pack_item(OP_READ_BYTE, 0, 0, 0), 1'b0, '0});
        script.push_back('{pack_item(OP_READ_BYTE, 0, 0, 0), 1'b1,
                           pack_reply(ST_SEQ, 0, 0, 1'b0)});
        script.push_back('{pack_item(OP_START_READ, 0, LEN_MAX, 0), 1'b1,
                           pack_reply(ST_EMPTY, 0, 0, 1'b0)});
        // An unaligned write position, and a read restarted before its byte.
        script.push_back('{pack_item(OP_START_WRITE, 1, 0, 0), 1'b0, '0});
        script.push_back('{pack_item(OP_WRITE_BYTE, 0, 0, 8'h80), 1'b0, '0});
        script.push_back('{pack_item(OP_START_READ, 0, LEN_MAX, 0), 1'b0, '0});
        script.push_back('{pack_item(OP_START_READ, 0, 1, 0), 1'b0, '0});
        script.push_back('{pack_item(OP_READ_BYTE, 0, 0, 0), 1'b0, '0});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) push_item(script[i].item, script[i].typed, script[i].reply);

        // Random traffic with idle bursts on both sides.
        mark = items_sent;
        while (items_sent - mark < RANDOM_ITEMS) random_episode();

        quiet = 1'b1;
        mark  = items_sent;
        while (items_sent - mark < TAIL_ITEMS) random_episode();

        s_valid <= 1'b0;
        while (ring_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/lpmr_pkg.sv
rtl/core/lpmr_store.sv
rtl/core/length_prefixed_message_ring.sv
tb/length_prefixed_message_ring_tb.sv
